[design/acps_pkg.sv]
package acps_pkg;

  localparam int unsigned KeystreamBytesDef = 65536;
  localparam int unsigned QDepth = 2;
  localparam logic [31:0] LcgInit = 32'h608da0a2;
  localparam logic [31:0] LcgMul = 32'h000343fd;
  localparam logic [31:0] LcgAdd = 32'h00269ec3;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_KSIZE  = 3'd4,
    REG_IV_HI  = 3'd5,
    REG_IV_LO  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [127:0] ctr;
    logic [7:0]   data;
    logic [3:0]   idx;
    logic         blk;
  } q_entry_t;

  typedef struct packed {
    logic [255:0] key;
    logic [1:0]   key_size;
    logic         key_change;
  } key_cfg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [16] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
    8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One cipher round on a big-endian state, byte n at bits 127-8n.
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int b = 0; b < 4; b++) begin
        t[4*c+b] = SBOX[s[127-8*(4*((c+b)%4)+b) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int n = 0; n < 16; n++) begin
      r[127-8*n -: 8] = t[n];
    end
    aes_round = r ^ rk;
  endfunction

endpackage

[design/acps_queue.sv]
module acps_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  acps_pkg::q_entry_t  wr_data_i,
  output logic                full_o,
  input  logic                rd_i,
  output acps_pkg::q_entry_t  rd_data_o,
  output logic                valid_o
);

  localparam int unsigned PtrW = $clog2(acps_pkg::QDepth);
  localparam int unsigned CntW = $clog2(acps_pkg::QDepth + 1);

  acps_pkg::q_entry_t mem_q [acps_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(acps_pkg::QDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(acps_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(acps_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[design/acps_front.sv]
module acps_front #(
  parameter int unsigned KEYSTREAM_BYTES = acps_pkg::KeystreamBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          cipher_byte_i,
  input  logic                restart_i,
  input  logic [127:0]        iv_i,
  output acps_pkg::q_entry_t  entry_o
);

  logic [15:0]  pos_q, pos_d, base_pos;
  logic [31:0]  seed_q, seed_d, base_seed, new_seed;
  logic [127:0] ctr_q, ctr_d, base_ctr, ctr_inc;
  logic [16:0]  next_pos;
  logic         blk, wrap;

  always_comb begin
    base_pos  = restart_i ? 16'd0 : pos_q;
    base_seed = restart_i ? acps_pkg::LcgInit : seed_q;
    base_ctr  = restart_i ? iv_i : ctr_q;
    blk       = (base_pos[3:0] == 4'd0);
    new_seed  = base_seed * acps_pkg::LcgMul + acps_pkg::LcgAdd;

    // carry stops below counter byte 0
    ctr_inc[63:0] = base_ctr[63:0] + 64'd1;
    ctr_inc[127:64] = base_ctr[127:64];
    if (ctr_inc[63:0] == 64'd0) begin
      ctr_inc[119:64] = base_ctr[119:64] + 56'd1;
    end

    next_pos = {1'b0, base_pos} + 17'd1;
    wrap     = (next_pos >= 17'(KEYSTREAM_BYTES)) || next_pos[16];

    entry_o.ctr  = base_ctr;
    entry_o.data = cipher_byte_i ^ new_seed[23:16];
    entry_o.idx  = base_pos[3:0];
    entry_o.blk  = blk;

    if (wrap) begin
      pos_d  = 16'd0;
      seed_d = acps_pkg::LcgInit;
      ctr_d  = iv_i;
    end else begin
      pos_d  = next_pos[15:0];
      seed_d = new_seed;
      ctr_d  = blk ? ctr_inc : base_ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seed_q <= acps_pkg::LcgInit;
      ctr_q  <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      seed_q <= seed_d;
      ctr_q  <= ctr_d;
    end
  end

endmodule

[design/acps_back.sv]
module acps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acps_pkg::key_cfg_t  cfg_i,
  input  acps_pkg::q_entry_t  head_i,
  input  logic                head_valid_i,
  output logic                head_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          plain_byte_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ENC} state_e;

  state_e state_q;
  logic [4:0]   k_q;
  logic [3:0]   round_q;
  logic [2:0]   ph_q;
  logic [3:0]   rc_q;
  logic [31:0]  win_q [8];
  logic [127:0] rk_q [15];
  logic [127:0] s_q, s_d, ks_q;
  logic         keys_ok_q, blk_done_q;
  logic [7:0]   ob_q [2];
  logic         ob_wr_q, ob_rd_q;
  logic [1:0]   ocnt_q;

  logic [3:0]   nk, nr;
  logic [4:0]   last_k;
  logic [2:0]   key_pairs;
  logic [31:0]  wa, wb, t;
  logic [63:0]  pair;
  logic [2:0]   ph_next;
  logic         out_push, out_pop;

  always_comb begin
    case (cfg_i.key_size)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr        = nk + 4'd6;
    last_k    = 5'({nr, 1'b1});
    key_pairs = nk[3:1];

    t = win_q[7];
    if (ph_q == 3'd0) begin
      t = acps_pkg::sub_word({t[23:0], t[31:24]}) ^ {acps_pkg::RCON[rc_q], 24'd0};
    end else if (nk == 4'd8 && ph_q == 3'd4) begin
      t = acps_pkg::sub_word(t);
    end
    case (nk)
      4'd4:    begin wa = win_q[4] ^ t; wb = win_q[5] ^ wa; end
      4'd6:    begin wa = win_q[2] ^ t; wb = win_q[3] ^ wa; end
      default: begin wa = win_q[0] ^ t; wb = win_q[1] ^ wa; end
    endcase
    ph_next = (4'(ph_q) + 4'd2 == nk) ? 3'd0 : ph_q + 3'd2;

    if (k_q < 5'(key_pairs)) begin
      pair = cfg_i.key[255-64*k_q[1:0] -: 64];
    end else begin
      pair = {wa, wb};
    end

    if (round_q == 4'd0) begin
      s_d = head_i.ctr ^ rk_q[0];
    end else begin
      s_d = acps_pkg::aes_round(s_q, rk_q[round_q], round_q == nr);
    end
  end

  assign out_pop    = pop_i && (ocnt_q != 2'd0);
  assign head_pop_o = (state_q == ST_IDLE) && head_valid_i &&
                      (!head_i.blk || blk_done_q) && (ocnt_q != 2'd2);
  assign out_push   = head_pop_o;
  assign empty_o      = (ocnt_q == 2'd0);
  assign plain_byte_o = ob_q[ob_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      round_q    <= '0;
      ph_q       <= '0;
      rc_q       <= 4'd1;
      keys_ok_q  <= 1'b0;
      blk_done_q <= 1'b0;
      ob_wr_q    <= 1'b0;
      ob_rd_q    <= 1'b0;
      ocnt_q     <= '0;
    end else begin
      if (cfg_i.key_change) begin
        keys_ok_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (head_pop_o) begin
            blk_done_q <= 1'b0;
          end else if (head_valid_i && head_i.blk && !blk_done_q) begin
            round_q <= '0;
            k_q     <= '0;
            state_q <= keys_ok_q ? ST_ENC : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          if (k_q < 5'(key_pairs)) begin
            ph_q <= '0;
            rc_q <= 4'd1;
          end else begin
            ph_q <= ph_next;
            if (ph_q == 3'd0) begin
              rc_q <= rc_q + 4'd1;
            end
          end
          k_q <= k_q + 5'd1;
          if (k_q == last_k) begin
            keys_ok_q <= 1'b1;
            state_q   <= ST_ENC;
          end
        end
        ST_ENC: begin
          round_q <= round_q + 4'd1;
          if (round_q == nr) begin
            blk_done_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_push) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (out_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
      if (out_push && !out_pop) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (out_pop && !out_push) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXPAND) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_q[i+2];
      end
      win_q[6] <= pair[63:32];
      win_q[7] <= pair[31:0];
      if (k_q[0]) begin
        rk_q[k_q[4:1]][63:0] <= pair;
      end else begin
        rk_q[k_q[4:1]][127:64] <= pair;
      end
    end
    if (state_q == ST_ENC) begin
      s_q <= s_d;
      if (round_q == nr) begin
        ks_q <= s_d;
      end
    end
    if (out_push) begin
      ob_q[ob_wr_q] <= head_i.data ^ ks_q[127-8*head_i.idx -: 8];
    end
  end

`ifndef SYNTHESIS
  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3) else $error("output buffer overrun");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENC) |-> (round_q <= nr)) else $error("round past last");
  a_blk_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop_o && head_i.blk) |-> blk_done_q) else $error("block used before keystream");
`endif

endmodule

[design/aes_ctr_pad_stream_decrypt_top.sv]
// Byte-stream decryptor: each ciphertext byte is XORed with an AES-CTR keystream byte
// and an LCG pad byte. Bytes within a 16-byte block pass at one per cycle while the
// two-byte output buffer is not full; the first byte of each block waits for one AES
// encryption on the iterative round unit. After reset and after any key or key-size
// write the round keys are re-expanded at the next block start, two words per cycle.
// Register writes take effect at the next block start, restart or keystream wrap.
module aes_ctr_pad_stream_decrypt_top #(
  parameter int unsigned KEYSTREAM_BYTES = acps_pkg::KeystreamBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cipher_byte_i,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  plain_byte_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key_q [4];
  logic [1:0]  key_size_q;
  logic [63:0] iv_hi_q, iv_lo_q;

  acps_pkg::q_entry_t  in_entry, head;
  acps_pkg::key_cfg_t  key_cfg;
  logic accept, head_valid, head_pop;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      key_size_q <= 2'd2;
      iv_hi_q    <= '0;
      iv_lo_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acps_pkg::REG_KEY0:  key_q[0]   <= cfg_data_i;
        acps_pkg::REG_KEY1:  key_q[1]   <= cfg_data_i;
        acps_pkg::REG_KEY2:  key_q[2]   <= cfg_data_i;
        acps_pkg::REG_KEY3:  key_q[3]   <= cfg_data_i;
        acps_pkg::REG_KSIZE: key_size_q <= cfg_data_i[1:0];
        acps_pkg::REG_IV_HI: iv_hi_q    <= cfg_data_i;
        acps_pkg::REG_IV_LO: iv_lo_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key_cfg.key        = {key_q[0], key_q[1], key_q[2], key_q[3]};
  assign key_cfg.key_size   = key_size_q;
  assign key_cfg.key_change = cfg_we_i && (cfg_idx_i <= acps_pkg::REG_KSIZE);

  acps_front #(.KEYSTREAM_BYTES(KEYSTREAM_BYTES)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .cipher_byte_i,
    .restart_i,
    .iv_i          ({iv_hi_q, iv_lo_q}),
    .entry_o       (in_entry)
  );

  acps_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i      (accept),
    .wr_data_i (in_entry),
    .full_o    (full),
    .rd_i      (head_pop),
    .rd_data_o (head),
    .valid_o   (head_valid)
  );

  acps_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (key_cfg),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .plain_byte_o
  );

endmodule
